@@ rtl/ipdb_pkg.sv @@
package ipdb_pkg;

	localparam int NUM_BITS_DEF  = 8;
	localparam int TIME_BITS_DEF = 20;

	localparam int COUNT_W   = 6;
	localparam int SLOT_W    = 6;
	localparam int CFG_IDX_W = 3;
	localparam int BYTE_W    = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int unsigned ZERO_MIN_RST  = 1000;
	localparam int unsigned ZERO_MAX_RST  = 1200;
	localparam int unsigned ONE_MIN_RST   = 2000;
	localparam int unsigned ONE_MAX_RST   = 2300;
	localparam int unsigned FIRST_SLOT_RST = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_MIN   = 3'd0,
		CFG_ZERO_MAX   = 3'd1,
		CFG_ONE_MIN    = 3'd2,
		CFG_ONE_MAX    = 3'd3,
		CFG_FIRST_SLOT = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		ACT_EDGE    = 1'b0,
		ACT_TIMEOUT = 1'b1
	} action_t;

	typedef struct packed {
		logic fire;
		logic timeout;
	} frame_ctl_t;

	typedef struct packed {
		logic               frame_active;
		logic [COUNT_W-1:0] edge_count;
	} frame_status_t;

endpackage

@@ rtl/ipdb_cfg_regs.sv @@
module ipdb_cfg_regs #(
	parameter int TIME_BITS = ipdb_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ipdb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [TIME_BITS-1:0]             cfg_wdata,
	output logic [TIME_BITS-1:0]             zero_min_q,
	output logic [TIME_BITS-1:0]             zero_max_q,
	output logic [TIME_BITS-1:0]             one_min_q,
	output logic [TIME_BITS-1:0]             one_max_q,
	output logic [ipdb_pkg::SLOT_W-1:0]      first_slot_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q   <= TIME_BITS'(ipdb_pkg::ZERO_MIN_RST);
			zero_max_q   <= TIME_BITS'(ipdb_pkg::ZERO_MAX_RST);
			one_min_q    <= TIME_BITS'(ipdb_pkg::ONE_MIN_RST);
			one_max_q    <= TIME_BITS'(ipdb_pkg::ONE_MAX_RST);
			first_slot_q <= ipdb_pkg::SLOT_W'(ipdb_pkg::FIRST_SLOT_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipdb_pkg::CFG_ZERO_MIN:   zero_min_q   <= cfg_wdata;
				ipdb_pkg::CFG_ZERO_MAX:   zero_max_q   <= cfg_wdata;
				ipdb_pkg::CFG_ONE_MIN:    one_min_q    <= cfg_wdata;
				ipdb_pkg::CFG_ONE_MAX:    one_max_q    <= cfg_wdata;
				ipdb_pkg::CFG_FIRST_SLOT: first_slot_q <= cfg_wdata[ipdb_pkg::SLOT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/ipdb_frame.sv @@
module ipdb_frame #(
	parameter int NUM_BITS  = ipdb_pkg::NUM_BITS_DEF,
	parameter int TIME_BITS = ipdb_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ipdb_pkg::frame_ctl_t          ctl,
	input  logic [TIME_BITS-1:0]          interval,
	input  logic [TIME_BITS-1:0]          zero_min,
	input  logic [TIME_BITS-1:0]          zero_max,
	input  logic [TIME_BITS-1:0]          one_min,
	input  logic [TIME_BITS-1:0]          one_max,
	input  logic [ipdb_pkg::SLOT_W-1:0]   first_slot,
	output logic [ipdb_pkg::BYTE_W-1:0]   data_byte,
	output ipdb_pkg::frame_status_t       status
);

	localparam int IDX_W = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

	logic                         frame_active_q;
	logic [ipdb_pkg::COUNT_W-1:0] edge_count_q;
	logic [TIME_BITS-1:0]         slot_q [NUM_BITS];
	logic [NUM_BITS-1:0]          held_q;
	logic [NUM_BITS-1:0]          held_d;
	logic [ipdb_pkg::COUNT_W:0]   rel;
	logic                         slot_hit;
	logic                         edge_fire;
	logic                         end_fire;

	assign edge_fire = ctl.fire && !ctl.timeout;
	assign end_fire  = ctl.fire && ctl.timeout && frame_active_q;

	// edge count relative to the first kept slot
	assign rel      = {1'b0, edge_count_q} - {1'b0, first_slot};
	assign slot_hit = !rel[ipdb_pkg::COUNT_W] &&
		(rel[ipdb_pkg::COUNT_W-1:0] < ipdb_pkg::COUNT_W'(NUM_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_active_q <= 1'b0;
			edge_count_q   <= '0;
			held_q         <= '0;
		end else if (edge_fire) begin
			frame_active_q <= 1'b1;
			if (frame_active_q && edge_count_q != ipdb_pkg::COUNT_MAX)
				edge_count_q <= edge_count_q + 1'b1;
		end else if (end_fire) begin
			frame_active_q <= 1'b0;
			edge_count_q   <= '0;
			held_q         <= held_d;
		end
	end

	for (genvar i = 0; i < NUM_BITS; i++) begin : g_slot
		logic zero_hit;
		logic one_hit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				slot_q[i] <= '0;
			else if (edge_fire && frame_active_q && slot_hit &&
					rel[IDX_W-1:0] == IDX_W'(i))
				slot_q[i] <= interval;
		end

		assign zero_hit = (slot_q[i] > zero_min) && (slot_q[i] < zero_max);
		assign one_hit  = (slot_q[i] > one_min) && (slot_q[i] < one_max);

		always_comb begin
			if (zero_hit)
				held_d[i] = 1'b0;
			else if (one_hit)
				held_d[i] = 1'b1;
			else
				held_d[i] = held_q[i];
		end
	end

	for (genvar b = 0; b < ipdb_pkg::BYTE_W; b++) begin : g_byte
		if (b < NUM_BITS) begin : g_bit
			assign data_byte[b] = held_d[b];
		end else begin : g_pad
			assign data_byte[b] = 1'b0;
		end
	end

	assign status.frame_active = frame_active_q;
	assign status.edge_count   = edge_count_q;

endmodule

@@ rtl/ir_pulse_distance_byte_decoder.sv @@
// IR pulse-distance byte decoder. Each input transaction is either a falling
// edge of the receiver (tuser 0, tdata holds the microseconds since the
// previous edge) or a frame timeout (tuser 1, tdata ignored). The first edge
// after idle opens a frame; later edges store their interval at the slot
// given by a count that saturates at 63, and only the NUM_BITS slots starting
// at first_slot are kept. A timeout during a frame classifies the kept
// intervals against the exclusive zero and one windows (an interval in
// neither window keeps that bit from the previous frame), sends one byte
// transaction and returns to idle; a timeout while idle gives nothing. One
// transaction is taken every clock cycle unless a frame end waits on a stalled
// output byte; each item passes the input register, then its byte the output
// register. The user must write registers through the cfg port only while no
// transaction is in flight; the block itself does not enforce this.
module ir_pulse_distance_byte_decoder #(
	parameter int NUM_BITS  = ipdb_pkg::NUM_BITS_DEF,
	parameter int TIME_BITS = ipdb_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ipdb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_BITS-1:0]           cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [((TIME_BITS+7)/8)*8-1:0] s_tdata,  // interval_us
	input  logic                           s_tuser,  // action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ipdb_pkg::BYTE_W-1:0]    m_tdata   // data_byte
);

	logic [TIME_BITS-1:0]         zero_min;
	logic [TIME_BITS-1:0]         zero_max;
	logic [TIME_BITS-1:0]         one_min;
	logic [TIME_BITS-1:0]         one_max;
	logic [ipdb_pkg::SLOT_W-1:0]  first_slot;

	logic                         valid_s1;
	ipdb_pkg::action_t            action_s1;
	logic [TIME_BITS-1:0]         interval_s1;

	ipdb_pkg::frame_ctl_t         ctl;
	ipdb_pkg::frame_status_t      status;
	logic [ipdb_pkg::BYTE_W-1:0]  byte_d;
	logic                         emit;
	logic                         advance;

	ipdb_cfg_regs #(
		.TIME_BITS (TIME_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.zero_min_q   (zero_min),
		.zero_max_q   (zero_max),
		.one_min_q    (one_min),
		.one_max_q    (one_max),
		.first_slot_q (first_slot)
	);

	assign emit     = valid_s1 && action_s1 == ipdb_pkg::ACT_TIMEOUT && status.frame_active;
	assign advance  = valid_s1 && (!emit || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1   <= ipdb_pkg::action_t'(s_tuser);
			interval_s1 <= s_tdata[TIME_BITS-1:0];
		end
	end

	assign ctl.fire    = advance;
	assign ctl.timeout = action_s1 == ipdb_pkg::ACT_TIMEOUT;

	ipdb_frame #(
		.NUM_BITS  (NUM_BITS),
		.TIME_BITS (TIME_BITS)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.interval   (interval_s1),
		.zero_min   (zero_min),
		.zero_max   (zero_max),
		.one_min    (one_min),
		.one_max    (one_max),
		.first_slot (first_slot),
		.data_byte  (byte_d),
		.status     (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (advance && emit)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			m_tdata <= byte_d;
	end

	a_timeout_emits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> m_tvalid)
		else $error("frame end did not produce a byte");

	a_edge_opens: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !ctl.timeout |=> status.frame_active)
		else $error("edge did not leave a frame open");

	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.timeout |=> !status.frame_active && status.edge_count == '0)
		else $error("timeout did not return to idle");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!status.frame_active |-> status.edge_count == '0)
		else $error("edge count moved while idle");

endmodule

@@ dv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipdb_pkg::*;

	localparam int TIME_W   = TIME_BITS_DEF;
	localparam int DATA_W   = ((TIME_BITS_DEF + 7) / 8) * 8;
	localparam int BITS     = NUM_BITS_DEF;
	localparam int TIME_MAX = (1 << TIME_BITS_DEF) - 1;

	localparam int EDGE_PROBES [8] = '{
		1001, 1199, 2001, 2299, 2300, 2000, 1200, 1000
	};

	typedef struct packed {
		action_t            act;
		logic [TIME_W-1:0]  interval;
	} ir_event_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata   = '0;  // interval_us
	logic                 s_tuser   = 1'b0;  // action
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [BYTE_W-1:0]    m_tdata;  // data_byte

	// decoder state as predicted
	logic                 frame_open = 1'b0;
	logic [COUNT_W-1:0]   edge_cnt   = '0;
	logic [TIME_W-1:0]    kept_intervals [BITS] = '{default: '0};
	logic [BITS-1:0]      last_byte  = '0;
	logic [TIME_W-1:0]    win_zero_lo = TIME_W'(ZERO_MIN_RST);
	logic [TIME_W-1:0]    win_zero_hi = TIME_W'(ZERO_MAX_RST);
	logic [TIME_W-1:0]    win_one_lo  = TIME_W'(ONE_MIN_RST);
	logic [TIME_W-1:0]    win_one_hi  = TIME_W'(ONE_MAX_RST);
	logic [SLOT_W-1:0]    lsb_slot    = SLOT_W'(FIRST_SLOT_RST);

	ir_event_t         pending_events [$];
	logic [BYTE_W-1:0] expected_bytes [$];
	int                errors         = 0;
	int                sender_idle_pct = 0;
	int                recv_stall_pct  = 0;
	logic              hold_off        = 1'b0;

	ir_pulse_distance_byte_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit decode_event(input ir_event_t ev, output logic [BYTE_W-1:0] decoded);
		int rel;
		decoded = last_byte;
		if (ev.act == ACT_EDGE) begin
			if (!frame_open) begin
				frame_open = 1'b1;
				return 1'b0;
			end
			rel = int'(edge_cnt) - int'(lsb_slot);
			if (rel >= 0 && rel < BITS)
				kept_intervals[rel] = ev.interval;
			if (edge_cnt != COUNT_MAX)
				edge_cnt = edge_cnt + 1'b1;
			return 1'b0;
		end
		if (!frame_open)
			return 1'b0;
		for (int i = 0; i < BITS; i++) begin
			if (kept_intervals[i] > win_zero_lo && kept_intervals[i] < win_zero_hi)
				last_byte[i] = 1'b0;
			else if (kept_intervals[i] > win_one_lo && kept_intervals[i] < win_one_hi)
				last_byte[i] = 1'b1;
		end
		frame_open = 1'b0;
		edge_cnt = '0;
		decoded = last_byte;
		return 1'b1;
	endfunction

	function automatic int clip_time(int v);
		return (v < 0) ? 0 : ((v > TIME_MAX) ? TIME_MAX : v);
	endfunction

	// mostly in or around the windows, some at their bounds, some anywhere
	function automatic logic [TIME_W-1:0] pick_interval();
		int lo, hi, t, sel, bound;
		sel = $urandom_range(9);
		if (sel < 3) begin
			lo = int'(win_zero_lo) - 2;
			hi = int'(win_zero_hi) + 2;
		end else if (sel < 6) begin
			lo = int'(win_one_lo) - 2;
			hi = int'(win_one_hi) + 2;
		end else if (sel == 6) begin
			case ($urandom_range(3))
				0: bound = int'(win_zero_lo);
				1: bound = int'(win_zero_hi);
				2: bound = int'(win_one_lo);
				default: bound = int'(win_one_hi);
			endcase
			lo = bound - 1;
			hi = bound + 1;
		end else begin
			lo = 0;
			hi = TIME_MAX;
		end
		lo = clip_time(lo);
		hi = clip_time(hi);
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		return TIME_W'($urandom_range(hi, lo));
	endfunction

	task automatic push_event(action_t a, logic [TIME_W-1:0] v);
		ir_event_t ev;
		ev.act = a;
		ev.interval = v;
		pending_events.push_back(ev);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [TIME_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_ZERO_MIN: win_zero_lo = val;
			CFG_ZERO_MAX: win_zero_hi = val;
			CFG_ONE_MIN: win_one_lo = val;
			CFG_ONE_MAX: win_one_hi = val;
			CFG_FIRST_SLOT: lsb_slot = val[SLOT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int z_lo, int z_hi, int o_lo, int o_hi, int slot);
		write_reg(CFG_ZERO_MIN, TIME_W'(z_lo));
		write_reg(CFG_ZERO_MAX, TIME_W'(z_hi));
		write_reg(CFG_ONE_MIN, TIME_W'(o_lo));
		write_reg(CFG_ONE_MAX, TIME_W'(o_hi));
		write_reg(CFG_FIRST_SLOT, TIME_W'(slot));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// edges carry no result, so allow for the pipeline after the last byte
	task automatic wait_idle();
		while (pending_events.size() != 0 || s_tvalid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic fill_random(int n_items);
		int pushed, len, r, n;
		pushed = 0;
		while (pushed < n_items) begin
			r = $urandom_range(19);
			if (r < 17) begin
				r = $urandom_range(19);
				if (r < 13)
					len = int'(lsb_slot) + BITS + $urandom_range(2);
				else if (r < 18)
					len = $urandom_range(int'(lsb_slot) + BITS + 1);
				else
					len = $urandom_range(72, 60);
				if (len > 72)
					len = 72;
				push_event(ACT_EDGE, TIME_W'($urandom_range(TIME_MAX)));
				repeat (len) push_event(ACT_EDGE, pick_interval());
				push_event(ACT_TIMEOUT, TIME_W'($urandom_range(TIME_MAX)));
				pushed += len + 2;
			end else begin
				n = $urandom_range(4, 1);
				repeat (n)
					push_event(action_t'($urandom_range(1)), TIME_W'($urandom_range(TIME_MAX)));
				pushed += n;
			end
		end
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int n_items);
		sender_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		fill_random(n_items);
		wait_idle();
	endtask

	always @(posedge clk) begin : drive_events
		ir_event_t ev;
		logic [BYTE_W-1:0] decoded;
		if (s_tvalid && s_tready) begin
			ev = pending_events.pop_front();
			if (decode_event(ev, decoded))
				expected_bytes.push_back(decoded);
		end
		if (s_tvalid && !s_tready) begin
			s_tvalid <= 1'b1;
		end else if (pending_events.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
			s_tvalid <= 1'b1;
			s_tdata <= DATA_W'(pending_events[0].interval);
			s_tuser <= pending_events[0].act;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_bytes
		logic [BYTE_W-1:0] want;
		if (m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: data byte expected none actual %02h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: data byte expected %02h actual %02h", $time, want, m_tdata);
					errors++;
				end
			end
		end
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// timeout while idle, full frame at reset windows, then a frame too short to reach the slots
		push_event(ACT_TIMEOUT, TIME_W'(TIME_MAX));
		push_event(ACT_EDGE, '0);
		for (int k = 0; k < 17; k++)
			push_event(ACT_EDGE, (k % 2) ? TIME_W'(TIME_MAX) : '0);
		for (int k = 0; k < BITS; k++)
			push_event(ACT_EDGE, TIME_W'(EDGE_PROBES[k]));
		push_event(ACT_TIMEOUT, 20'h5a5a5);
		push_event(ACT_EDGE, 20'h0a5a5);
		push_event(ACT_TIMEOUT, '0);
		wait_idle();

		run_phase(0, 0, 250);

		set_config(0, TIME_MAX, 0, TIME_MAX, 0);
		run_phase(53, 0, 250);

		set_config(TIME_MAX, 0, 0, TIME_MAX, 63);
		run_phase(0, 53, 250);

		set_config(1500, 1700, 1600, 3000, 56);
		run_phase(16, 16, 200);

		// output held off while short frames keep coming
		set_config(10, 20, 30, 40, 0);
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		fork
			begin : stall_receiver
				hold_off <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		repeat (30) begin
			push_event(ACT_EDGE, pick_interval());
			repeat ($urandom_range(3)) push_event(ACT_EDGE, pick_interval());
			push_event(ACT_TIMEOUT, TIME_W'($urandom_range(TIME_MAX)));
		end
		wait_idle();

		set_config(ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, FIRST_SLOT_RST);
		run_phase(16, 16, 200);

		repeat (10) @(posedge clk);
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("ir_pulse_distance_byte_decoder test passed");
		end else begin
			$display("ir_pulse_distance_byte_decoder test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("ir_pulse_distance_byte_decoder test failed");
		$finish;
	end

endmodule
